// ===== rtl/mcrt_pkg.sv =====
// Package for the multi-channel repeat timer: operation codes, the per-channel
// record kept in channel memory, and the command and status groups that pass
// between controller and datapath. No dependencies.
`default_nettype none

package mcrt_pkg;

	// Operation carried in the input tuser bit.
	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} op_t;

	localparam int CH_W      = 4;
	localparam int PERIOD_W  = 15;
	localparam int REPEATS_W = 8;

	// A repeat count of this value never runs down.
	localparam logic [REPEATS_W-1:0] FOREVER_COUNT = 8'd255;

	// One channel's record as stored in channel memory.
	typedef struct packed {
		logic                 mode;
		logic [REPEATS_W-1:0] remaining;
		logic [PERIOD_W-1:0]  reload;
		logic [PERIOD_W-1:0]  countdown;
	} chan_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // write a start request into its channel
		logic start_scan; // read channel zero to open a tick scan
		logic run;        // evaluate the channel at the head of the scan
		logic flush;      // hand the held event out as the final one
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;  // the last channel was evaluated this cycle
		logic flush_done; // no event is held any longer
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mcrt_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
`default_nettype none

module mcrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while the read enable is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/mcrt_ctrl.sv =====
// Controller for the multi-channel repeat timer: sequences idle, channel scan
// and final-event flush. Depends on mcrt_pkg.
`default_nettype none

module mcrt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              op,
	input  wire mcrt_pkg::dp_stat_t stat,
	output logic                   ready,
	output mcrt_pkg::dp_cmd_t      cmd
);

	import mcrt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   ready_q;

	// State and the registered ready output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && op == OP_TICK) begin
						state_q <= ST_SCAN;
						ready_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (stat.scan_done) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (stat.flush_done) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	// Commands follow the state and the accepted request.
	always_comb begin
		cmd.load       = accept && op == OP_START;
		cmd.start_scan = accept && op == OP_TICK;
		cmd.run        = state_q == ST_SCAN;
		cmd.flush      = state_q == ST_FLUSH;
	end

	assign ready = ready_q;

endmodule

`default_nettype wire

// ===== rtl/mcrt_dp.sv =====
// Datapath for the multi-channel repeat timer: channel memory, active flags,
// per-channel countdown update, held event and output register.
// Depends on mcrt_pkg and mcrt_ram.
`default_nettype none

module mcrt_dp #(
	parameter int CHANNELS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mcrt_pkg::dp_cmd_t                 cmd,
	output mcrt_pkg::dp_stat_t                     stat,
	input  wire logic [mcrt_pkg::CH_W-1:0]         channel,
	input  wire logic [mcrt_pkg::PERIOD_W-1:0]     period,
	input  wire logic [mcrt_pkg::REPEATS_W-1:0]    repeats,
	input  wire logic                              notify_mode,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [mcrt_pkg::CH_W-1:0]              fired_channel,
	output logic                                   fired_mode,
	output logic                                   last
);

	import mcrt_pkg::*;

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [CHANNELS-1:0] active_q;
	logic [IW-1:0]       eval_idx_q;
	logic                pend_vld_q;
	logic [CH_W-1:0]     pend_ch_q;
	logic                pend_mode_q;
	logic                out_vld_q;
	logic [CH_W-1:0]     out_ch_q;
	logic                out_mode_q;
	logic                out_last_q;

	chan_word_t          rd_word;
	chan_word_t          ev_word;
	chan_word_t          ld_word;
	chan_word_t          wr_word;
	logic [PERIOD_W-1:0] cd_dec;
	logic                ch_active;
	logic                rem_zero;
	logic                fire;
	logic                out_free;
	logic                stall;
	logic                eval_ok;
	logic                is_last;
	logic                in_range;
	logic                out_load;
	logic                we;
	logic [IW-1:0]       waddr;
	logic                re;
	logic [IW-1:0]       raddr;

	// Channel records; the read port is registered, so the record of the scanned
	// channel arrives in the cycle after its read.
	mcrt_ram #(
		.WIDTH ($bits(chan_word_t)),
		.DEPTH (CHANNELS)
	) u_chan_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_word),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_word)
	);

	// Evaluate the channel at the head of the scan.
	always_comb begin
		ch_active = active_q[eval_idx_q];
		rem_zero  = rd_word.remaining == '0;
		cd_dec    = (rd_word.countdown != '0) ? rd_word.countdown - PERIOD_W'(1) : '0;
		fire      = cmd.run && ch_active && !rem_zero && cd_dec == '0;
		out_free  = !out_vld_q || out_ready;
		stall     = fire && pend_vld_q && !out_free;
		eval_ok   = cmd.run && !stall;
		is_last   = eval_idx_q == IW'(CHANNELS - 1);

		ev_word           = rd_word;
		ev_word.countdown = fire ? rd_word.reload : cd_dec;
		if (fire && rd_word.remaining != FOREVER_COUNT) begin
			ev_word.remaining = rd_word.remaining - REPEATS_W'(1);
		end
	end

	// A start request loads period, repeat count and mode.
	always_comb begin
		in_range          = 32'(channel) < CHANNELS;
		ld_word.mode      = notify_mode;
		ld_word.remaining = repeats;
		ld_word.reload    = period;
		ld_word.countdown = period;
	end

	// Memory port control: loads happen only while idle, write-backs only
	// during the scan.
	always_comb begin
		we      = (cmd.load && in_range) || (eval_ok && ch_active && !rem_zero);
		waddr   = cmd.load ? IW'(channel) : eval_idx_q;
		wr_word = cmd.load ? ld_word : ev_word;
		re      = cmd.start_scan || (eval_ok && !is_last);
		raddr   = cmd.start_scan ? '0 : eval_idx_q + IW'(1);
	end

	always_comb begin
		stat.scan_done  = eval_ok && is_last;
		stat.flush_done = cmd.flush && (!pend_vld_q || out_free);
		out_load        = (fire && !stall && pend_vld_q) ||
		                  (cmd.flush && pend_vld_q && out_free);
	end

	// Control state: active flags, scan position and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			eval_idx_q <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (cmd.load && in_range) begin
				active_q[IW'(channel)] <= 1'b1;
			end
			if (eval_ok && ch_active && rem_zero) begin
				active_q[eval_idx_q] <= 1'b0;
			end
			if (cmd.start_scan) begin
				eval_idx_q <= '0;
			end else if (eval_ok && !is_last) begin
				eval_idx_q <= eval_idx_q + IW'(1);
			end
			if (fire && !stall) begin
				pend_vld_q <= 1'b1;
			end
			if (cmd.flush && pend_vld_q && out_free) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	// Event payload: a new event is held until the next one shows it was not
	// the final event of the tick.
	always_ff @(posedge clk) begin
		if (fire && !stall) begin
			pend_ch_q   <= CH_W'(eval_idx_q);
			pend_mode_q <= rd_word.mode;
			if (pend_vld_q) begin
				out_ch_q   <= pend_ch_q;
				out_mode_q <= pend_mode_q;
				out_last_q <= 1'b0;
			end
		end
		if (cmd.flush && pend_vld_q && out_free) begin
			out_ch_q   <= pend_ch_q;
			out_mode_q <= pend_mode_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid     = out_vld_q;
	assign fired_channel = out_ch_q;
	assign fired_mode    = out_mode_q;
	assign last          = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/multi_channel_repeat_timer.sv =====
// Multi-channel repeat timer, top level. A start request leaves the input open.
// A tick request scans one channel per cycle; the scan pauses while an event
// waits on a full output register. The first event of a tick leaves once the
// next event or the end of the scan is known. Reset (arst_n, asynchronous) makes
// every channel inactive and empties the output; channel memory is not cleared.
`default_nettype none

module multi_channel_repeat_timer #(
	parameter int CHANNELS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // channel[3:0], period[18:4], repeats[26:19],
	                                   // notify_mode[27], zero[31:28]
	input  wire logic        s_tuser,  // op[0]: 0 tick, 1 start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // fired_channel[3:0], fired_mode[4], zero[7:5]
	output logic             m_tlast   // last
);

	import mcrt_pkg::*;

	dp_cmd_t         cmd;
	dp_stat_t        stat;
	logic            accept;
	logic [CH_W-1:0] fired_channel;
	logic            fired_mode;

	assign accept = s_tvalid && s_tready;

	mcrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (s_tuser),
		.stat   (stat),
		.ready  (s_tready),
		.cmd    (cmd)
	);

	mcrt_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.channel       (s_tdata[3:0]),
		.period        (s_tdata[18:4]),
		.repeats       (s_tdata[26:19]),
		.notify_mode   (s_tdata[27]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.fired_channel (fired_channel),
		.fired_mode    (fired_mode),
		.last          (m_tlast)
	);

	assign m_tdata = {3'b000, fired_mode, fired_channel};

	// A tick closes the input until its scan and flush are over.
	a_tick_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_TICK |=> !s_tready)
		else $error("input still open after a tick request");

	// A start request leaves the input open.
	a_start_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_START |=> s_tready)
		else $error("input closed after a start request");

	// No request is taken while the channels are being scanned.
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run || cmd.flush |-> !s_tready)
		else $error("input open during a scan");

endmodule

`default_nettype wire

// ===== verif/multi_channel_repeat_timer_tb.sv =====
// Self-checking testbench for multi_channel_repeat_timer: start and tick requests go
// in on the slave stream, and expiry events are checked against a channel-bank predictor.
// Depends on rtl/mcrt_pkg.sv and rtl/multi_channel_repeat_timer.sv.

module multi_channel_repeat_timer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mcrt_pkg::*;

	localparam int CHANNELS      = 16;
	localparam int RANDOM_ITEMS  = 324;
	localparam int IDLE_PCT      = 38;
	localparam int RX_HOLD_LEN   = 300;
	localparam int SETTLE_CYCLES = 3 * (CHANNELS + 2);
	localparam int CYCLE_LIMIT   = 600000;

	// Entries of the stimulus queue: real requests plus markers that steer the sender.
	typedef enum logic [2:0] {
		K_REQ,
		K_DRAIN,
		K_CALM,
		K_NOISY,
		K_RX_HOLD
	} step_kind_t;

	typedef struct {
		step_kind_t            kind;
		op_t                   op;
		logic [CH_W-1:0]       chan;
		logic [PERIOD_W-1:0]   period;
		logic [REPEATS_W-1:0]  repeats;
		logic                  mode;
	} timer_req_t;

	typedef struct {
		logic [CH_W-1:0] chan;
		logic            mode;
		logic            last;
	} fire_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	timer_req_t pending_reqs[$];
	timer_req_t cur_req;
	fire_t      expected_fires[$];

	int  offered_cnt    = 0;
	int  accepted_cnt   = 0;
	int  mismatch_count = 0;
	int  cycle_count    = 0;
	bit  calm           = 1'b0;
	int  rx_hold_asks   = 0;
	int  rx_hold_served = 0;
	int  rx_hold_left   = 0;

	// Predicted state of the channel bank.
	logic                 chan_on     [CHANNELS];
	logic [PERIOD_W-1:0]  chan_count  [CHANNELS];
	logic [PERIOD_W-1:0]  chan_period [CHANNELS];
	logic [REPEATS_W-1:0] chan_left   [CHANNELS];
	logic                 chan_mode   [CHANNELS];

	multi_channel_repeat_timer #(
		.CHANNELS(CHANNELS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic add_start(input int ch, input int per, input int rep, input bit md);
		timer_req_t r;
		r.kind    = K_REQ;
		r.op      = OP_START;
		r.chan    = CH_W'(ch);
		r.period  = PERIOD_W'(per);
		r.repeats = REPEATS_W'(rep);
		r.mode    = md;
		pending_reqs.push_back(r);
	endtask

	task automatic add_ticks(input int n);
		timer_req_t r;
		r.kind    = K_REQ;
		r.op      = OP_TICK;
		r.chan    = '0;
		r.period  = '0;
		r.repeats = '0;
		r.mode    = 1'b0;
		repeat (n) begin
			// Fields are ignored on a tick, so fill them with noise.
			r.chan    = CH_W'($urandom);
			r.period  = PERIOD_W'($urandom);
			r.repeats = REPEATS_W'($urandom);
			r.mode    = 1'($urandom);
			pending_reqs.push_back(r);
		end
	endtask

	task automatic add_mark(input step_kind_t k);
		timer_req_t r;
		r.kind    = k;
		r.op      = OP_TICK;
		r.chan    = '0;
		r.period  = '0;
		r.repeats = '0;
		r.mode    = 1'b0;
		pending_reqs.push_back(r);
	endtask

	// One tick: visit the active channels in index order and queue their expiry events.
	function automatic void advance_timers();
		fire_t held;
		bit    have_held;
		have_held = 1'b0;
		held      = '{default: '0};
		for (int i = 0; i < CHANNELS; i++) begin
			if (!chan_on[i])
				continue;
			if (chan_left[i] == '0) begin
				chan_on[i] = 1'b0;
				continue;
			end
			if (chan_count[i] != '0)
				chan_count[i] = chan_count[i] - 1'b1;
			if (chan_count[i] == '0) begin
				if (have_held)
					expected_fires.push_back(held);
				held.chan  = CH_W'(i);
				held.mode  = chan_mode[i];
				held.last  = 1'b0;
				have_held  = 1'b1;
				chan_count[i] = chan_period[i];
				if (chan_left[i] != FOREVER_COUNT)
					chan_left[i] = chan_left[i] - 1'b1;
			end
		end
		// The final event of the tick carries tlast.
		if (have_held) begin
			held.last = 1'b1;
			expected_fires.push_back(held);
		end
	endfunction

	// Rising edge: check delivered events, then update the prediction for accepted requests.
	always @(posedge clk) begin
		fire_t want;
		cycle_count++;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_fires.size() == 0) begin
					report_mismatch($sformatf("unexpected event on channel %0d", m_tdata[3:0]));
				end else begin
					want = expected_fires.pop_front();
					if (m_tdata[3:0] !== want.chan)
						report_mismatch($sformatf("fired_channel %0d, expected %0d",
							m_tdata[3:0], want.chan));
					if (m_tdata[4] !== want.mode)
						report_mismatch($sformatf("fired_mode %0b on channel %0d, expected %0b",
							m_tdata[4], want.chan, want.mode));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last %0b on channel %0d, expected %0b",
							m_tlast, want.chan, want.last));
				end
			end
			if (s_tvalid && s_tready) begin
				accepted_cnt++;
				if (cur_req.op == OP_START) begin
					chan_count[cur_req.chan]  = cur_req.period;
					chan_period[cur_req.chan] = cur_req.period;
					chan_left[cur_req.chan]   = cur_req.repeats;
					chan_mode[cur_req.chan]   = cur_req.mode;
					chan_on[cur_req.chan]     = 1'b1;
				end else begin
					advance_timers();
				end
			end
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("multi_channel_repeat_timer_tb: done, errors");
			$finish;
		end
	end

	// Sender: holds a request until it is taken, then offers the next one or idles.
	always @(negedge clk) begin
		if (!arst_n || (s_tvalid && accepted_cnt != offered_cnt)) begin
			// Keep the current request on the bus.
		end else if (pending_reqs.size() == 0) begin
			s_tvalid <= 1'b0;
		end else begin
			case (pending_reqs[0].kind)
				K_REQ: begin
					if (!calm && $urandom_range(99) < IDLE_PCT) begin
						s_tvalid <= 1'b0;
					end else begin
						cur_req = pending_reqs.pop_front();
						s_tdata  <= {4'b0, cur_req.mode, cur_req.repeats, cur_req.period,
							cur_req.chan};
						s_tuser  <= cur_req.op;
						s_tvalid <= 1'b1;
						offered_cnt++;
					end
				end
				K_DRAIN: begin
					s_tvalid <= 1'b0;
					if (expected_fires.size() == 0)
						pending_reqs.delete(0);
				end
				K_CALM: begin
					s_tvalid <= 1'b0;
					calm = 1'b1;
					pending_reqs.delete(0);
				end
				K_NOISY: begin
					s_tvalid <= 1'b0;
					calm = 1'b0;
					pending_reqs.delete(0);
				end
				default: begin
					s_tvalid <= 1'b0;
					rx_hold_asks++;
					pending_reqs.delete(0);
				end
			endcase
		end
	end

	// Receiver: random back-pressure, plus a long hold-off when the sender asks for one.
	always @(negedge clk) begin
		if (rx_hold_asks != rx_hold_served) begin
			rx_hold_served++;
			rx_hold_left = RX_HOLD_LEN;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			m_tready <= 1'b0;
			rx_hold_left--;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int                   sel;
		int                   per;
		int                   rep;
		for (int i = 0; i < CHANNELS; i++) begin
			chan_on[i]     = 1'b0;
			chan_count[i]  = '0;
			chan_period[i] = '0;
			chan_left[i]   = '0;
			chan_mode[i]   = 1'b0;
		end

		// Directed: idle tick, single expiry then silent stop, zero repeats,
		// longest period with forever, restart of an active channel.
		add_ticks(1);
		add_start(0, 0, 1, 1'b0);
		add_ticks(2);
		add_start(3, 5, 0, 1'b1);
		add_start(15, 32767, 255, 1'b1);
		add_start(5, 1, 2, 1'b1);
		add_start(9, 0, 255, 1'b0);
		add_start(5, 0, 3, 1'b0);
		add_start(12, 2, 1, 1'b1);
		add_ticks(5);
		add_mark(K_DRAIN);

		// Pressure: every channel fires on each of the first three ticks while the receiver holds off.
		for (int i = 0; i < CHANNELS; i++)
			add_start(i, 0, 3, 1'(i));
		add_mark(K_RX_HOLD);
		add_ticks(5);
		add_mark(K_DRAIN);

		// Random: mostly short periods and small repeat counts so that events are frequent.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == 120)
				add_mark(K_CALM);
			if (k == 200)
				add_mark(K_NOISY);
			if (k % 90 == 89)
				add_mark(K_DRAIN);
			if ($urandom_range(99) < 35) begin
				sel = $urandom_range(9);
				if (sel < 7)
					per = $urandom_range(4);
				else if (sel < 9)
					per = $urandom_range(40, 5);
				else
					per = $urandom_range(32767);
				sel = $urandom_range(9);
				if (sel < 5)
					rep = $urandom_range(5);
				else if (sel < 7)
					rep = FOREVER_COUNT;
				else
					rep = $urandom_range(255);
				add_start($urandom_range(CHANNELS - 1), per, rep, 1'($urandom));
			end else begin
				add_ticks(1);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid || expected_fires.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_fires.size() != 0)
			report_mismatch($sformatf("%0d events never arrived", expected_fires.size()));

		if (mismatch_count == 0)
			$display("multi_channel_repeat_timer_tb: done, clean");
		else
			$display("multi_channel_repeat_timer_tb: done, errors");
		$finish;
	end

endmodule
